// File: src/brle_pkg.sv
// ----------------------------------------------------------------------------
// Bitmap row RLE encoder package
// Shared types and constants for the row-packed bitmap run-length encoder.
// ----------------------------------------------------------------------------
package brle_pkg;

   localparam int unsigned ByteWidth    = 8;
   localparam int unsigned RunLenWidth  = 9;
   localparam int unsigned MaxGroup     = 3;
   localparam int unsigned GroupCntW    = 2;
   localparam int unsigned QueueDepth   = 2;
   localparam int unsigned QueuePtrW    = 1;
   localparam int unsigned QueueCntW    = 2;
   localparam int unsigned CsrAddrWidth = 3;
   localparam int unsigned CsrDataWidth = 32;

   localparam logic [RunLenWidth-1:0] RunCap    = 9'd256;
   localparam logic [ByteWidth-1:0]   ByteZeros = 8'h00;
   localparam logic [ByteWidth-1:0]   ByteOnes  = 8'hFF;
   localparam logic [ByteWidth-1:0]   CountOne  = 8'h01;

   localparam logic [0:0] RegInvert = 1'b0;

   // Results produced by one request, in output order.
   typedef struct packed {
      logic [GroupCntW-1:0]                count;
      logic [MaxGroup-1:0][ByteWidth-1:0]  bytes;
   } brle_group_type;

endpackage

// File: src/brle_core.sv
// ----------------------------------------------------------------------------
// Bitmap row RLE encoder core
// Packs one pixel group into a byte, tracks the open run and produces the
// zero to three result bytes that the request causes.
// ----------------------------------------------------------------------------
module brle_core import brle_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  logic [ByteWidth-1:0]  pixels,
   input  logic                  row_end,
   input  logic                  invert,
   output brle_group_type        group
);

   logic                    run_active_ff, run_active_in;
   logic                    run_ones_ff, run_ones_in;
   logic [RunLenWidth-1:0]  run_len_ff, run_len_in;

   logic [ByteWidth-1:0]    packed_byte;
   logic                    is_run_byte;
   logic                    is_ones;
   logic [RunLenWidth-1:0]  len_inc;

   assign packed_byte = invert ? pixels : ~pixels;
   assign is_ones     = (packed_byte == ByteOnes);
   assign is_run_byte = is_ones || (packed_byte == ByteZeros);
   assign len_inc     = run_len_ff + RunLenWidth'(1);

   always_comb begin
      group         = '0;
      run_active_in = run_active_ff;
      run_ones_in   = run_ones_ff;
      run_len_in    = run_len_ff;
      if (run_active_ff && is_run_byte && (run_ones_ff == is_ones)) begin
         if ((len_inc == RunCap) || row_end) begin
            group.count    = GroupCntW'(1);
            group.bytes[0] = len_inc[ByteWidth-1:0];
            run_active_in  = 1'b0;
            run_ones_in    = 1'b0;
            run_len_in     = '0;
         end else begin
            run_len_in = len_inc;
         end
      end else begin
         if (is_run_byte && !row_end) begin
            run_active_in = 1'b1;
            run_ones_in   = is_ones;
            run_len_in    = RunLenWidth'(1);
         end else begin
            run_active_in = 1'b0;
            run_ones_in   = 1'b0;
            run_len_in    = '0;
         end
         if (run_active_ff) begin
            group.bytes[0] = run_len_ff[ByteWidth-1:0];
            group.bytes[1] = packed_byte;
            group.bytes[2] = CountOne;
            group.count    = (is_run_byte && row_end) ? GroupCntW'(3) : GroupCntW'(2);
         end else begin
            group.bytes[0] = packed_byte;
            group.bytes[1] = CountOne;
            group.count    = (is_run_byte && row_end) ? GroupCntW'(2) : GroupCntW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_active_ff <= 1'b0;
         run_ones_ff   <= 1'b0;
         run_len_ff    <= '0;
      end else if (step) begin
         run_active_ff <= run_active_in;
         run_ones_ff   <= run_ones_in;
         run_len_ff    <= run_len_in;
      end
   end

endmodule

// File: src/brle_serializer.sv
// ----------------------------------------------------------------------------
// Bitmap row RLE encoder serializer
// Queues result groups and sends them out one byte per cycle while rsp_tready
// is high, through a registered output stage.
// ----------------------------------------------------------------------------
module brle_serializer import brle_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  brle_group_type        group,
   output logic                  full,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [ByteWidth-1:0]  rsp_tdata,   // out_byte[7:0]
   output logic                  rsp_tlast
);

   brle_group_type          entries_ff [QueueDepth];
   logic [QueuePtrW-1:0]    wr_ptr_ff, rd_ptr_ff;
   logic [QueueCntW-1:0]    count_ff, count_in;
   logic [GroupCntW-1:0]    sel_ff, sel_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [ByteWidth-1:0]    rsp_data_ff;
   logic                    rsp_last_ff;

   brle_group_type          head;
   logic                    load;
   logic                    pop;

   assign head = entries_ff[rd_ptr_ff];
   assign full = (count_ff == QueueCntW'(QueueDepth));
   assign load = (count_ff != '0) && (!rsp_valid_ff || rsp_tready);
   assign pop  = load && (sel_ff == GroupCntW'(head.count - GroupCntW'(1)));

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = QueueCntW'(count_ff + QueueCntW'(1));
      end else if (pop && !push) begin
         count_in = QueueCntW'(count_ff - QueueCntW'(1));
      end
      sel_in = sel_ff;
      if (load) begin
         sel_in = pop ? '0 : GroupCntW'(sel_ff + GroupCntW'(1));
      end
      rsp_valid_in = load ? 1'b1 : (rsp_valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff    <= '0;
         rd_ptr_ff    <= '0;
         count_ff     <= '0;
         sel_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (push) begin
            wr_ptr_ff <= QueuePtrW'(wr_ptr_ff + QueuePtrW'(1));
         end
         if (pop) begin
            rd_ptr_ff <= QueuePtrW'(rd_ptr_ff + QueuePtrW'(1));
         end
         count_ff     <= count_in;
         sel_ff       <= sel_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= group;
      end
      if (load) begin
         rsp_data_ff <= head.bytes[sel_ff];
         rsp_last_ff <= pop;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

// File: src/bitmap_row_pack_rle_encoder.sv
// ----------------------------------------------------------------------------
// Bitmap row RLE encoder
// Run-length encodes row-packed monochrome bitmap bytes.
// ----------------------------------------------------------------------------
// Each request carries eight pixels and a row-end flag and produces zero to
// three result bytes: literal bytes, or a run value followed later by its
// count, where a count of 256 is sent as 0 and runs stop at row ends. The
// block takes a request in every cycle as long as its two-entry group queue
// has room, and the output sends one byte per cycle while rsp_tready is high,
// so sustained throughput is bounded by the bytes that each request produces.
// A request passes through the input register, the group queue and the
// registered output stage before its first result byte appears. Write the
// invert register only while the block is idle.
module bitmap_row_pack_rle_encoder import brle_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [ByteWidth-1:0]     req_tdata,   // pixels[7:0]
   input  logic                     req_tlast,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [ByteWidth-1:0]     rsp_tdata,   // out_byte[7:0]
   output logic                     rsp_tlast,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CsrAddrWidth-1:0]  csr_paddr,
   input  logic [CsrDataWidth-1:0]  csr_pwdata,
   output logic [CsrDataWidth-1:0]  csr_prdata,
   output logic                     csr_pready
);

   logic                    invert_ff;
   logic                    in_valid_ff;
   logic [ByteWidth-1:0]    in_pixels_ff;
   logic                    in_last_ff;
   logic                    step;
   logic                    full;
   logic                    req_accept;
   logic                    csr_write;
   logic [0:0]              csr_index;
   brle_group_type          group;

   assign csr_pready = 1'b1;
   assign csr_index  = csr_paddr[2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_index == RegInvert) ?
                       {{(CsrDataWidth-1){1'b0}}, invert_ff} : '0;

   assign step       = in_valid_ff && !full;
   assign req_tready = !in_valid_ff || step;
   assign req_accept = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         invert_ff   <= 1'b0;
         in_valid_ff <= 1'b0;
      end else begin
         if (csr_write && (csr_index == RegInvert)) begin
            invert_ff <= csr_pwdata[0];
         end
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_pixels_ff <= req_tdata;
         in_last_ff   <= req_tlast;
      end
   end

   brle_core u_core (
      .clock   (clock),
      .reset   (reset),
      .step    (step),
      .pixels  (in_pixels_ff),
      .row_end (in_last_ff),
      .invert  (invert_ff),
      .group   (group)
   );

   brle_serializer u_serializer (
      .clock      (clock),
      .reset      (reset),
      .push       (step && (group.count != '0)),
      .group      (group),
      .full       (full),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   a_input_hold: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !step) |=> (in_valid_ff && $stable(in_pixels_ff) && $stable(in_last_ff)))
      else $error("held request changed while waiting for queue space");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !in_valid_ff |-> req_tready)
      else $error("request refused with an empty input register");

   a_row_end_emits: assert property (@(posedge clock) disable iff (reset)
      (step && in_last_ff) |-> (group.count != '0))
      else $error("row end produced no result");

endmodule
